// ----- rtl/core/patch_ncc_cost_macros.svh -----
// ----------------------------------------------------------------------------
// patch_ncc_cost_macros.svh
// assertion macros shared by the patch correlation cost block
// ----------------------------------------------------------------------------
`ifndef PATCH_NCC_COST_MACROS_SVH
`define PATCH_NCC_COST_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PNC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("patch_ncc_cost: assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define PNC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("patch_ncc_cost: assertion failed");

`endif

// ----- rtl/core/pnc_pkg.sv -----
// ----------------------------------------------------------------------------
// pnc_pkg
// types, sequencer states and constants of the patch correlation cost block
// ----------------------------------------------------------------------------
package pnc_pkg;

	// one patch pixel
	typedef struct packed {
		logic [7:0]  ref_red;
		logic [7:0]  ref_green;
		logic [7:0]  ref_blue;
		logic [15:0] other_red;
		logic [15:0] other_green;
		logic [15:0] other_blue;
		logic        other_valid;
		logic        last_pixel;
	} pixel_t;

	// one patch result
	typedef struct packed {
		logic signed [15:0] ncc_cost;
		logic               no_valid;
	} result_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ACC_MUL,
		ST_ACC_ADD,
		ST_FIN_INIT,
		ST_FIN_MUL,
		ST_FIN_ADD,
		ST_ROOT_X_GO,
		ST_ROOT_X_WAIT,
		ST_ROOT_Y_GO,
		ST_ROOT_Y_WAIT,
		ST_DEN_MUL,
		ST_DIV_INIT,
		ST_DIV,
		ST_NEXT_CH,
		ST_DIV3_MUL,
		ST_DIV3_FIX,
		ST_RESULT
	} state_t;

	// accumulation products per channel
	localparam logic [2:0] AOP_XX = 3'd0;
	localparam logic [2:0] AOP_YY = 3'd1;
	localparam logic [2:0] AOP_XY = 3'd2;

	// finishing micro-ops per channel
	localparam logic [2:0] FOP_NXX    = 3'd0;
	localparam logic [2:0] FOP_SXSX   = 3'd1;
	localparam logic [2:0] FOP_NYY_LO = 3'd2;
	localparam logic [2:0] FOP_NYY_HI = 3'd3;
	localparam logic [2:0] FOP_SYSY   = 3'd4;
	localparam logic [2:0] FOP_NXY_LO = 3'd5;
	localparam logic [2:0] FOP_NXY_HI = 3'd6;
	localparam logic [2:0] FOP_SXSY   = 3'd7;

	localparam logic [1:0] CH_LAST    = 2'd2;
	localparam logic [3:0] DIV_LAST   = 4'd13;
	localparam logic [31:0] DIV3_RECIP = 32'd43691;
	localparam logic [14:0] NCC_ONE   = 15'd16384;
	localparam logic signed [15:0] NCC_NO_VALID = -16'sd16384;

endpackage

// ----- rtl/core/pnc_isqrt.sv -----
// ----------------------------------------------------------------------------
// pnc_isqrt
// iterative floor square root, 64-bit operand, one result bit per cycle
// ----------------------------------------------------------------------------
module pnc_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic        done,
	output logic [31:0] root
);
	logic        busy_q;
	logic        done_q;
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = r_q + bit_q;
	assign done  = done_q;
	assign root  = r_q[31:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && bit_q[0];
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	// digit-by-digit root, bit walks down two places a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			r_q   <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// ----- rtl/core/patch_ncc_cost.sv -----
// ----------------------------------------------------------------------------
// patch_ncc_cost
// normalized cross-correlation cost of an RGB patch pair, Q1.14 result
// ----------------------------------------------------------------------------
// Usage: pixels of a patch enter on pixel with start; an item is taken when
// start is high and busy is low. Invalid pixels are dropped; valid ones add
// to per-channel sums, squared sums and cross sums (up to MAX_PATCH_PIXELS
// valid pixels per patch, more are dropped).
// A dropped non-last pixel leaves busy low. A valid pixel holds busy while
// nine products pass through the one shared 32x32 multiplier, each in a
// multiply state followed by an add state.
// On the last pixel the block finishes the patch: per channel eight
// multiply/add micro-ops, two square roots in the root unit, one multiply
// and a 14-step restoring divide (a flat channel skips the roots and the
// divide), then a reciprocal multiply divides the channel sum by three.
// The result appears on result for one cycle with result_valid, then the
// sums clear for the next patch. The receiver cannot stall the result.
// Reset clears all sums, the pixel count and the sequencer.
// ----------------------------------------------------------------------------
`include "patch_ncc_cost_macros.svh"

module patch_ncc_cost #(
	parameter int MAX_PATCH_PIXELS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pnc_pkg::pixel_t  pixel,
	output logic             result_valid,
	output pnc_pkg::result_t result
);
	import pnc_pkg::*;

	localparam int CW   = $clog2(MAX_PATCH_PIXELS + 1);
	localparam int SXW  = 8 + CW;
	localparam int SYW  = 16 + CW;
	localparam int SXXW = 16 + CW;
	localparam int SYYW = 32 + CW;
	localparam int SXYW = 24 + CW;

	state_t state_q, state_d;

	logic [CW-1:0]   cnt_q;
	logic [1:0]      ch_q;
	logic [2:0]      op_q;
	logic [3:0]      step_q;
	logic [SXW-1:0]  s_x_q  [3];
	logic [SYW-1:0]  s_y_q  [3];
	logic [SXXW-1:0] s_xx_q [3];
	logic [SYYW-1:0] s_yy_q [3];
	logic [SXYW-1:0] s_xy_q [3];

	pixel_t              pix_q;
	logic [63:0]         mul_q;
	logic signed [63:0]  acc_q;
	logic signed [63:0]  acc_d;
	logic [63:0]         vx_q;
	logic [63:0]         vy_q;
	logic signed [63:0]  a_q;
	logic [31:0]         rx_q;
	logic [31:0]         ry_q;
	logic [63:0]         den_q;
	logic [63:0]         rem_q;
	logic [14:0]         mag_q;
	logic signed [16:0]  total_q;
	result_t             res_q;

	logic        accept;
	logic        acc_ok;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic        root_start;
	logic [63:0] root_value;
	logic        root_done;
	logic [31:0] root;
	logic        flat;
	logic [63:0] abs_a;
	logic [63:0] rem0;
	logic [63:0] rem2;
	logic [16:0] abs_total;
	logic [7:0]  x_in [3];
	logic [15:0] y_in [3];
	logic [7:0]  x_cur;
	logic [15:0] y_cur;
	logic [63:0] n64;
	logic [63:0] sx64;
	logic [63:0] sy64;
	logic [63:0] sxx64;
	logic [63:0] syy64;
	logic [63:0] sxy64;

	// handshake and admission
	assign accept = start && !busy;
	assign acc_ok = pixel.other_valid && (cnt_q < CW'(MAX_PATCH_PIXELS));

	// channel lanes of the incoming pixel
	assign x_in[0] = pixel.ref_red;
	assign x_in[1] = pixel.ref_green;
	assign x_in[2] = pixel.ref_blue;
	assign y_in[0] = pixel.other_red;
	assign y_in[1] = pixel.other_green;
	assign y_in[2] = pixel.other_blue;

	// current channel of the held pixel
	always_comb begin
		unique case (ch_q)
			2'd0: begin
				x_cur = pix_q.ref_red;
				y_cur = pix_q.other_red;
			end
			2'd1: begin
				x_cur = pix_q.ref_green;
				y_cur = pix_q.other_green;
			end
			default: begin
				x_cur = pix_q.ref_blue;
				y_cur = pix_q.other_blue;
			end
		endcase
	end

	// sums of the current channel, widened
	assign n64   = 64'(cnt_q);
	assign sx64  = 64'(s_x_q[ch_q]);
	assign sy64  = 64'(s_y_q[ch_q]);
	assign sxx64 = 64'(s_xx_q[ch_q]);
	assign syy64 = 64'(s_yy_q[ch_q]);
	assign sxy64 = 64'(s_xy_q[ch_q]);

	// derived values for divide and final scaling
	assign flat      = (vx_q == 64'd0) || (vy_q == 64'd0);
	assign abs_a     = a_q[63] ? 64'(-a_q) : 64'(a_q);
	assign rem0      = abs_a << 11;
	assign rem2      = rem_q << 1;
	assign abs_total = total_q[16] ? 17'(-total_q) : 17'(total_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (acc_ok) begin
						state_d = ST_ACC_MUL;
					end else if (pixel.last_pixel) begin
						state_d = ST_FIN_INIT;
					end
				end
			end
			ST_ACC_MUL:     state_d = ST_ACC_ADD;
			ST_ACC_ADD: begin
				if (ch_q == CH_LAST && op_q == AOP_XY) begin
					state_d = pix_q.last_pixel ? ST_FIN_INIT : ST_IDLE;
				end else begin
					state_d = ST_ACC_MUL;
				end
			end
			ST_FIN_INIT:    state_d = (cnt_q == '0) ? ST_RESULT : ST_FIN_MUL;
			ST_FIN_MUL:     state_d = ST_FIN_ADD;
			ST_FIN_ADD: begin
				if (op_q == FOP_SXSY) begin
					state_d = flat ? ST_NEXT_CH : ST_ROOT_X_GO;
				end else begin
					state_d = ST_FIN_MUL;
				end
			end
			ST_ROOT_X_GO:   state_d = ST_ROOT_X_WAIT;
			ST_ROOT_X_WAIT: state_d = root_done ? ST_ROOT_Y_GO : ST_ROOT_X_WAIT;
			ST_ROOT_Y_GO:   state_d = ST_ROOT_Y_WAIT;
			ST_ROOT_Y_WAIT: state_d = root_done ? ST_DEN_MUL : ST_ROOT_Y_WAIT;
			ST_DEN_MUL:     state_d = ST_DIV_INIT;
			ST_DIV_INIT:    state_d = (rem0 >= mul_q) ? ST_NEXT_CH : ST_DIV;
			ST_DIV:         state_d = (step_q == DIV_LAST) ? ST_NEXT_CH : ST_DIV;
			ST_NEXT_CH:     state_d = (ch_q == CH_LAST) ? ST_DIV3_MUL : ST_FIN_MUL;
			ST_DIV3_MUL:    state_d = ST_DIV3_FIX;
			ST_DIV3_FIX:    state_d = ST_RESULT;
			ST_RESULT:      state_d = ST_IDLE;
			default:        state_d = ST_IDLE;
		endcase
	end

	// state decoded outputs and shared multiplier operands
	always_comb begin
		busy         = (state_q != ST_IDLE);
		result_valid = (state_q == ST_RESULT);
		result       = res_q;
		root_start   = (state_q == ST_ROOT_X_GO) || (state_q == ST_ROOT_Y_GO);
		root_value   = (state_q == ST_ROOT_X_GO) ? {vx_q[47:0], 16'd0}
		                                         : {vy_q[57:0], 6'd0};
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_ACC_MUL: begin
				unique case (op_q)
					AOP_XX: begin
						mul_a = 32'(x_cur);
						mul_b = 32'(x_cur);
					end
					AOP_YY: begin
						mul_a = 32'(y_cur);
						mul_b = 32'(y_cur);
					end
					default: begin
						mul_a = 32'(x_cur);
						mul_b = 32'(y_cur);
					end
				endcase
			end
			ST_FIN_MUL: begin
				unique case (op_q)
					FOP_NXX: begin
						mul_a = n64[31:0];
						mul_b = sxx64[31:0];
					end
					FOP_SXSX: begin
						mul_a = sx64[31:0];
						mul_b = sx64[31:0];
					end
					FOP_NYY_LO: begin
						mul_a = n64[31:0];
						mul_b = syy64[31:0];
					end
					FOP_NYY_HI: begin
						mul_a = n64[31:0];
						mul_b = syy64[63:32];
					end
					FOP_SYSY: begin
						mul_a = sy64[31:0];
						mul_b = sy64[31:0];
					end
					FOP_NXY_LO: begin
						mul_a = n64[31:0];
						mul_b = sxy64[31:0];
					end
					FOP_NXY_HI: begin
						mul_a = n64[31:0];
						mul_b = sxy64[63:32];
					end
					default: begin
						mul_a = sx64[31:0];
						mul_b = sy64[31:0];
					end
				endcase
			end
			ST_DEN_MUL: begin
				mul_a = rx_q;
				mul_b = ry_q;
			end
			ST_DIV3_MUL: begin
				mul_a = 32'(abs_total);
				mul_b = DIV3_RECIP;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// accumulator of the finishing micro-ops
	always_comb begin
		acc_d = acc_q;
		unique case (op_q)
			FOP_NXX, FOP_NYY_LO, FOP_NXY_LO: acc_d = $signed(mul_q);
			FOP_SXSX, FOP_SYSY, FOP_SXSY:    acc_d = acc_q - $signed(mul_q);
			default:                         acc_d = acc_q + $signed(mul_q << 32);
		endcase
	end

	// sequencer, counters and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ch_q    <= '0;
			op_q    <= '0;
			step_q  <= '0;
			for (int c = 0; c < 3; c++) begin
				s_x_q[c]  <= '0;
				s_y_q[c]  <= '0;
				s_xx_q[c] <= '0;
				s_yy_q[c] <= '0;
				s_xy_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					ch_q <= '0;
					op_q <= '0;
					if (accept && acc_ok) begin
						cnt_q <= cnt_q + 1'b1;
						for (int c = 0; c < 3; c++) begin
							s_x_q[c] <= s_x_q[c] + SXW'(x_in[c]);
							s_y_q[c] <= s_y_q[c] + SYW'(y_in[c]);
						end
					end
				end
				ST_ACC_ADD: begin
					unique case (op_q)
						AOP_XX:  s_xx_q[ch_q] <= s_xx_q[ch_q] + SXXW'(mul_q);
						AOP_YY:  s_yy_q[ch_q] <= s_yy_q[ch_q] + SYYW'(mul_q);
						default: s_xy_q[ch_q] <= s_xy_q[ch_q] + SXYW'(mul_q);
					endcase
					if (op_q == AOP_XY) begin
						op_q <= '0;
						ch_q <= ch_q + 1'b1;
					end else begin
						op_q <= op_q + 1'b1;
					end
				end
				ST_FIN_INIT: begin
					ch_q <= '0;
					op_q <= '0;
				end
				ST_FIN_ADD:  op_q   <= op_q + 1'b1;
				ST_DIV_INIT: step_q <= '0;
				ST_DIV:      step_q <= step_q + 1'b1;
				ST_NEXT_CH: begin
					ch_q <= ch_q + 1'b1;
					op_q <= '0;
				end
				ST_RESULT: begin
					cnt_q <= '0;
					for (int c = 0; c < 3; c++) begin
						s_x_q[c]  <= '0;
						s_y_q[c]  <= '0;
						s_xx_q[c] <= '0;
						s_yy_q[c] <= '0;
						s_xy_q[c] <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		mul_q <= 64'(mul_a) * 64'(mul_b);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pix_q <= pixel;
				end
			end
			ST_FIN_INIT: begin
				total_q        <= '0;
				res_q.ncc_cost <= NCC_NO_VALID;
				res_q.no_valid <= 1'b1;
			end
			ST_FIN_ADD: begin
				acc_q <= acc_d;
				if (op_q == FOP_SXSX) begin
					vx_q <= 64'(acc_d);
				end
				if (op_q == FOP_SYSY) begin
					vy_q <= 64'(acc_d);
				end
				if (op_q == FOP_SXSY) begin
					a_q   <= acc_d;
					mag_q <= '0;
				end
			end
			ST_ROOT_X_WAIT: begin
				if (root_done) begin
					rx_q <= root;
				end
			end
			ST_ROOT_Y_WAIT: begin
				if (root_done) begin
					ry_q <= root;
				end
			end
			ST_DIV_INIT: begin
				den_q <= mul_q;
				rem_q <= rem0;
				mag_q <= (rem0 >= mul_q) ? NCC_ONE : 15'd0;
			end
			ST_DIV: begin
				if (rem2 >= den_q) begin
					rem_q <= rem2 - den_q;
					mag_q <= {mag_q[13:0], 1'b1};
				end else begin
					rem_q <= rem2;
					mag_q <= {mag_q[13:0], 1'b0};
				end
			end
			ST_NEXT_CH: begin
				total_q <= a_q[63] ? (total_q - $signed(17'(mag_q)))
				                   : (total_q + $signed(17'(mag_q)));
			end
			ST_DIV3_FIX: begin
				res_q.ncc_cost <= total_q[16] ? -$signed(16'(mul_q[31:17]))
				                              : $signed(16'(mul_q[31:17]));
				res_q.no_valid <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	// shared square root unit
	pnc_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.value  (root_value),
		.done   (root_done),
		.root   (root)
	);

	// checks
	`PNC_ASSERT_NOW(a_strobe_busy, result_valid, busy)
	`PNC_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid)
	`PNC_ASSERT_NOW(a_no_valid_cost, result_valid && result.no_valid,
		result.ncc_cost == NCC_NO_VALID)
	`PNC_ASSERT_NOW(a_cost_range, result_valid,
		(result.ncc_cost >= -16'sd16384) && (result.ncc_cost <= 16'sd16384))

endmodule
